// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file scfr_checker.sv.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, ignored while reset is asserted.
`define SCFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define SCFR_ASSERT_IMPL(label, ante, cons, msg) \
	`SCFR_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- hdl/scfr_pkg.sv -----
// Package for the sync-word CRC-8 frame receiver: types, codes, CRC functions.
// No dependencies.
package scfr_pkg;

	localparam logic [7:0]  MIN_LEN        = 8'd4;
	localparam logic [7:0]  MAX_FRAME      = 8'd64;
	localparam logic [7:0]  FIRST_POS      = 8'd3;
	localparam logic [23:0] SYNC_RESET     = 24'hC56A29;
	localparam logic [7:0]  CRC_POLY_REFL  = 8'h8C;

	localparam logic [1:0] STATUS_BUSY = 2'd0;
	localparam logic [1:0] STATUS_GOOD = 2'd1;
	localparam logic [1:0] STATUS_BAD  = 2'd2;
	localparam logic [1:0] STATUS_LEN  = 2'd3;

	typedef struct packed {
		logic       vld;
		logic [7:0] frame_byte;
		logic [7:0] position;
		logic       last;
		logic [1:0] status;
	} scfr_result_t;

	// CRC-8/Maxim, reflected, one byte.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY_REFL;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	// CRC of the three sync bytes from a zero start, first byte in bits 23:16.
	function automatic logic [7:0] crc8_sync(input logic [23:0] pat);
		logic [7:0] c;
		c = crc8_update(8'h00, pat[23:16]);
		c = crc8_update(c, pat[15:8]);
		c = crc8_update(c, pat[7:0]);
		return c;
	endfunction

endpackage

// ----- hdl/scfr_in_reg.sv -----
// Input register stage of the frame receiver.
// Depends on nothing outside this file.
module scfr_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       space,
	output logic       take,
	output logic [7:0] byte_s1
);

	logic valid_s1;

	assign take     = valid_s1 & space;
	assign in_ready = ~valid_s1 | take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ----- hdl/scfr_deframer.sv -----
// Sync hunt, length check and running CRC-8 for one byte per cycle while take is high.
// Depends on scfr_pkg.
module scfr_deframer
	import scfr_pkg::*;
#(
	parameter logic [7:0] MAX_LEN = MAX_FRAME
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [23:0]  cfg_wr_data,
	input  logic         take,
	input  logic [7:0]   byte_s1,
	output scfr_result_t res
);

	logic        in_frame_q, in_frame_d;
	logic [15:0] history_q, history_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  frame_length_q, frame_length_d;
	logic [7:0]  crc_q, crc_d;
	logic [23:0] sync_q;
	logic [7:0]  sync_crc_q;

	logic [23:0] window;
	logic        first;
	logic [7:0]  len_eff;
	logic        len_bad;
	logic        at_end;

	assign window  = {history_q, byte_s1};
	assign first   = (byte_count_q == FIRST_POS);
	assign len_eff = first ? byte_s1 : frame_length_q;
	assign len_bad = first && ((byte_s1 < MIN_LEN) || (byte_s1 > MAX_LEN));
	assign at_end  = (({1'b0, byte_count_q} + 9'd1) == {1'b0, len_eff});

	always_comb begin
		in_frame_d     = in_frame_q;
		history_d      = history_q;
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		crc_d          = crc_q;
		res.vld        = 1'b0;
		res.frame_byte = byte_s1;
		res.position   = byte_count_q;
		res.last       = 1'b0;
		res.status     = STATUS_BUSY;
		if (!in_frame_q) begin
			if (window == sync_q) begin
				in_frame_d     = 1'b1;
				byte_count_d   = FIRST_POS;
				frame_length_d = 8'd0;
				history_d      = 16'd0;
				crc_d          = sync_crc_q;
			end else begin
				history_d = window[15:0];
			end
		end else begin
			res.vld = 1'b1;
			if (len_bad || at_end) begin
				// frame done or aborted: back to hunting
				res.last       = 1'b1;
				res.status     = len_bad ? STATUS_LEN :
					((byte_s1 == crc_q) ? STATUS_GOOD : STATUS_BAD);
				in_frame_d     = 1'b0;
				history_d      = 16'd0;
				byte_count_d   = 8'd0;
				frame_length_d = 8'd0;
				crc_d          = 8'd0;
			end else begin
				crc_d        = crc8_update(crc_q, byte_s1);
				byte_count_d = byte_count_q + 8'd1;
				if (first) begin
					frame_length_d = byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			history_q      <= 16'd0;
			byte_count_q   <= 8'd0;
			frame_length_q <= 8'd0;
			crc_q          <= 8'd0;
		end else if (take) begin
			in_frame_q     <= in_frame_d;
			history_q      <= history_d;
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			crc_q          <= crc_d;
		end
	end

	// sync CRC is loaded together with the pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q     <= SYNC_RESET;
			sync_crc_q <= crc8_sync(SYNC_RESET);
		end else if (cfg_wr_en) begin
			sync_q     <= cfg_wr_data;
			sync_crc_q <= crc8_sync(cfg_wr_data);
		end
	end

endmodule

// ----- hdl/scfr_out_reg.sv -----
// Output result register of the frame receiver.
// Depends on scfr_pkg.
module scfr_out_reg
	import scfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  scfr_result_t res,
	output logic         space,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   frame_byte,
	output logic [7:0]   position,
	output logic         last,
	output logic [1:0]   status
);

	logic out_valid_q;
	logic load;

	assign space     = ~out_valid_q | out_ready;
	assign load      = take & res.vld;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_byte <= res.frame_byte;
			position   <= res.position;
			last       <= res.last;
			status     <= res.status;
		end
	end

endmodule

// ----- hdl/sync_crc8_frame_receiver_core.sv -----
// Top level of the sync-word CRC-8/Maxim frame receiver; uses scfr_pkg and the scfr_* stages.
// Path: a byte is registered in scfr_in_reg, processed by scfr_deframer when taken, and its result
// is registered in scfr_out_reg, which drives out_valid; a stalled result holds the byte in scfr_in_reg.
// Throughput: one byte per cycle unless a stalled result blocks take; the CRC byte update is combinational.
// Reset (arst_n, async low): hunting, history/CRC/count clear, sync pattern 0xC56A29.
module sync_crc8_frame_receiver_core
	import scfr_pkg::*;
#(
	// largest accepted frame length, sync and check byte included
	parameter logic [7:0] MAX_LEN = MAX_FRAME
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: sync pattern, first byte in bits 23:16
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	// byte input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic [7:0]  position,
	output logic        last,
	output logic [1:0]  status
);

	// The input stage holds one byte. It is processed (take) whenever the
	// output register is empty or being drained; bytes that yield no result
	// (sync hunt) still wait for that slot, which costs nothing at full rate.
	logic         take;
	logic         space;
	logic [7:0]   byte_s1;
	scfr_result_t res;

	scfr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.space    (space),
		.take     (take),
		.byte_s1  (byte_s1)
	);

	// Frame state: hunt window, byte position, frame length and running CRC.
	// The CRC of the sync bytes is kept precomputed from the pattern register.
	scfr_deframer #(
		.MAX_LEN (MAX_LEN)
	) u_dfr (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.take        (take),
		.byte_s1     (byte_s1),
		.res         (res)
	);

	// Result register: holds one transaction; the next byte is taken only while it is empty or being drained.
	scfr_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.res        (res),
		.space      (space),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.position   (position),
		.last       (last),
		.status     (status)
	);

endmodule

// ----- hdl/scfr_checker.sv -----
// Port-level checks for the frame receiver, bound to the top level.
// Depends on scfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scfr_checker
	import scfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic [7:0] position,
	input logic       last,
	input logic [1:0] status
);

	// a stalled result holds
	`SCFR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(frame_byte) && $stable(position) && $stable(last) && $stable(status)), "stalled result changed")
	// a draining output never blocks the input
	`SCFR_ASSERT_IMPL(a_ready_flow, out_ready, in_ready, "input stalled while output drains")
	// final status only with last, and last only with a final status
	`SCFR_ASSERT_IMPL(a_last_status, out_valid, (last == (status != STATUS_BUSY)), "last and status disagree")
	// length abort only on the length byte
	`SCFR_ASSERT_IMPL(a_len_pos, (out_valid && status == STATUS_LEN), (position == FIRST_POS), "length abort off the length byte")
	// echoed bytes never carry a sync position
	`SCFR_ASSERT_IMPL(a_pos_min, out_valid, (position >= FIRST_POS), "result at sync position")

endmodule

bind sync_crc8_frame_receiver_core scfr_checker u_scfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frame_byte (frame_byte),
	.position   (position),
	.last       (last),
	.status     (status)
);
